>>> sv/zfs_pkg.sv
package zfs_pkg;

  localparam int FRAC_BITS = 30;
  localparam int ALIGN_HI  = 30;
  localparam int ALIGN_LO  = 29;
  localparam int DIV_STEPS = 33;

  localparam logic [63:0]        ONE_FX   = 64'd1 << FRAC_BITS;
  localparam logic [63:0]        HALF_FX  = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_S64  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ONE_SQ   = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic signed [31:0] ONE_S32  = 32'sd1 <<< FRAC_BITS;
  localparam logic [31:0]        SAT32    = 32'hFFFF_FFFF;
  localparam logic [63:0]        SQRT_TOP = 64'd1 << 62;

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic signed [63:0] fx_round(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + HALF_FX) >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat_one(input logic signed [63:0] v);
    if (v > ONE_S64) begin
      return ONE_S32;
    end else if (v < -ONE_S64) begin
      return -ONE_S32;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

endpackage

>>> sv/zone_frame_and_scale.sv
// Zone frame and position scale.
// Input channel: in_valid_i / in_stall_o carry one zone triangle per transfer
// (zone index and three Q2.30 corner vectors). Output channel: out_valid_o /
// out_stall_i carry the zone index, the normalized center, both tangent axes
// and the running maximum position scale.
// The block works on one triangle at a time and holds in_stall_o high from
// the accepted transfer until its result transfer completes. For one
// triangle, each of the two normalizations of a nonzero vector needs an
// alignment by shifting, a 32-step square root and three 33-step divisions,
// and each corner needs a square root and two divisions unless its projection
// saturates or its radicand is not positive. All of these run one bit per
// cycle on a single shared square-root, divider and multiplier datapath. A new
// triangle is taken in the cycle after the result transfer at the earliest.
// While the receiver stalls, the result stays on the output ports unchanged
// and no new triangle is taken. Reset empties the block and clears the
// running scale to zero; it is never cleared otherwise.
module zone_frame_and_scale
  import zfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        zone_index_i,
  input  logic signed [31:0] v0_x_i,
  input  logic signed [31:0] v0_y_i,
  input  logic signed [31:0] v0_z_i,
  input  logic signed [31:0] v1_x_i,
  input  logic signed [31:0] v1_y_i,
  input  logic signed [31:0] v1_z_i,
  input  logic signed [31:0] v2_x_i,
  input  logic signed [31:0] v2_y_i,
  input  logic signed [31:0] v2_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        zone_out_o,
  output logic signed [31:0] center_x_o,
  output logic signed [31:0] center_y_o,
  output logic signed [31:0] center_z_o,
  output logic signed [31:0] axis_a_x_o,
  output logic signed [31:0] axis_a_y_o,
  output logic signed [31:0] axis_a_z_o,
  output logic signed [31:0] axis_b_x_o,
  output logic signed [31:0] axis_b_y_o,
  output logic signed [31:0] axis_b_z_o,
  output logic [31:0]        scale_max_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ALIGN, S_SQ, S_SQRT, S_NDIV, S_DIV, S_NST, S_NFIN, S_BX, S_BXST,
    S_PROJ, S_MCHK, S_RAD, S_RCHK, S_HDIV, S_HST, S_DONE
  } state_e;

  state_e      state_q;
  logic [1:0]  k_q, crn_q;
  logic        t_q, ph_q, nsel_q, scl_q;
  logic [5:0]  cnt_q;
  logic        out_valid_q;
  logic [31:0] run_q;

  logic [15:0]        zone_q;
  logic signed [31:0] v_q [3][3];
  logic signed [31:0] ctr_q [3];
  logic signed [31:0] ax_q [3];
  logic signed [31:0] bx_q [3];
  logic [33:0]        nm_q [3];
  logic [2:0]         nneg_q;
  logic signed [63:0] acc_q, prod_q;
  logic signed [35:0] mu0_q, mu1_q;
  logic [63:0]        sx_q, sres_q, sbit_q;
  logic [31:0]        rem_q, den_q;
  logic [32:0]        dq_q, quo_q;
  logic               ovf_q;

  logic               in_acc;
  logic               all_zero, any_hi, all_lo;
  logic [35:0]        m0, m1, mt;
  logic               mu_sat;
  logic [1:0]         i1, i2, ia, ib;
  logic signed [33:0] dsub, mul_a, mul_b;
  logic signed [67:0] prod_full;
  logic signed [63:0] rnd;
  logic [63:0]        div_num;
  logic [32:0]        div_tr;
  logic               div_ge;
  logic [32:0]        div_sub;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [32:0]        nq;
  logic signed [31:0] n_val;
  logic [31:0]        h_val;
  logic signed [33:0] sum_x, sum_y, sum_z;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sum_x = sx34(v0_x_i) + sx34(v1_x_i) + sx34(v2_x_i);
  assign sum_y = sx34(v0_y_i) + sx34(v1_y_i) + sx34(v2_y_i);
  assign sum_z = sx34(v0_z_i) + sx34(v1_z_i) + sx34(v2_z_i);

  assign all_zero = (nm_q[0] == '0) && (nm_q[1] == '0) && (nm_q[2] == '0);
  assign any_hi   = (|nm_q[0][33:ALIGN_HI]) || (|nm_q[1][33:ALIGN_HI]) ||
                    (|nm_q[2][33:ALIGN_HI]);
  assign all_lo   = !(|nm_q[0][33:ALIGN_LO]) && !(|nm_q[1][33:ALIGN_LO]) &&
                    !(|nm_q[2][33:ALIGN_LO]);

  assign m0     = mu0_q[35] ? 36'(-mu0_q) : 36'(mu0_q);
  assign m1     = mu1_q[35] ? 36'(-mu1_q) : 36'(mu1_q);
  assign mt     = t_q ? m1 : m0;
  assign mu_sat = (64'(m0) >= ONE_FX) || (64'(m1) >= ONE_FX);

  assign i1 = nxt3(k_q);
  assign i2 = nxt3(i1);
  assign ia = t_q ? i2 : i1;
  assign ib = t_q ? i1 : i2;

  assign dsub = sx34(v_q[crn_q][k_q]) - sx34(ctr_q[k_q]);

  always_comb begin
    unique case (state_q)
      S_SQ: begin
        mul_a = $signed(nm_q[k_q]);
        mul_b = $signed(nm_q[k_q]);
      end
      S_BX: begin
        mul_a = sx34(ctr_q[ia]);
        mul_b = sx34(ax_q[ib]);
      end
      S_PROJ: begin
        mul_a = dsub;
        mul_b = sx34(t_q ? bx_q[k_q] : ax_q[k_q]);
      end
      S_RAD: begin
        mul_a = $signed(mt[33:0]);
        mul_b = $signed(mt[33:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign rnd       = fx_round(prod_q);

  assign div_num = ((scl_q ? 64'(mt) : 64'(nm_q[k_q])) << FRAC_BITS) + 64'(sres_q[31:1]);
  assign div_tr  = {rem_q, dq_q[32]};
  assign div_ge  = div_tr >= {1'b0, den_q};
  assign div_sub = div_tr - {1'b0, den_q};

  assign sq_t  = sres_q + sbit_q;
  assign sq_ge = sx_q >= sq_t;

  assign nq    = (quo_q > 33'(ONE_FX)) ? 33'(ONE_FX) : quo_q;
  assign n_val = nneg_q[k_q] ? -$signed(nq[31:0]) : $signed(nq[31:0]);
  assign h_val = (ovf_q || quo_q[32]) ? SAT32 : quo_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      crn_q       <= '0;
      t_q         <= 1'b0;
      ph_q        <= 1'b0;
      nsel_q      <= 1'b0;
      scl_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      run_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_ALIGN;
            nsel_q  <= 1'b0;
            scl_q   <= 1'b0;
          end
        end
        S_ALIGN: begin
          if (all_zero) begin
            state_q <= S_NFIN;
          end else if (!any_hi && !all_lo) begin
            state_q <= S_SQ;
            k_q     <= '0;
            ph_q    <= 1'b0;
          end
        end
        S_SQ: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (k_q == 2'd2) begin
              state_q <= S_SQRT;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_SQRT: begin
          if (sbit_q == '0) begin
            k_q     <= '0;
            t_q     <= 1'b0;
            state_q <= scl_q ? S_HDIV : S_NDIV;
          end
        end
        S_NDIV, S_HDIV: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            state_q <= scl_q ? S_HST : S_NST;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_NST: begin
          if (k_q == 2'd2) begin
            state_q <= S_NFIN;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_NDIV;
          end
        end
        S_NFIN: begin
          if (!nsel_q) begin
            nsel_q  <= 1'b1;
            state_q <= S_ALIGN;
          end else begin
            k_q     <= '0;
            t_q     <= 1'b0;
            ph_q    <= 1'b0;
            state_q <= S_BX;
          end
        end
        S_BX: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (!t_q) begin
              t_q <= 1'b1;
            end else begin
              state_q <= S_BXST;
            end
          end
        end
        S_BXST: begin
          t_q  <= 1'b0;
          ph_q <= 1'b0;
          if (k_q == 2'd2) begin
            k_q     <= '0;
            crn_q   <= '0;
            scl_q   <= 1'b1;
            state_q <= S_PROJ;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_BX;
          end
        end
        S_PROJ: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (!t_q) begin
              t_q <= 1'b1;
            end else begin
              t_q <= 1'b0;
              if (k_q == 2'd2) begin
                state_q <= S_MCHK;
              end else begin
                k_q <= k_q + 2'd1;
              end
            end
          end
        end
        S_MCHK, S_RCHK, S_HST: begin
          if ((state_q == S_MCHK && !mu_sat) || (state_q == S_RCHK && acc_q > 0)) begin
            t_q     <= 1'b0;
            ph_q    <= 1'b0;
            state_q <= (state_q == S_MCHK) ? S_RAD : S_SQRT;
          end else if (state_q == S_HST && !t_q) begin
            if (h_val > run_q) begin
              run_q <= h_val;
            end
            t_q     <= 1'b1;
            state_q <= S_HDIV;
          end else begin
            if (state_q == S_HST) begin
              if (h_val > run_q) begin
                run_q <= h_val;
              end
            end else begin
              run_q <= SAT32;
            end
            if (crn_q == 2'd2) begin
              out_valid_q <= 1'b1;
              state_q     <= S_DONE;
            end else begin
              crn_q   <= crn_q + 2'd1;
              k_q     <= '0;
              t_q     <= 1'b0;
              ph_q    <= 1'b0;
              state_q <= S_PROJ;
            end
          end
        end
        S_RAD: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (!t_q) begin
              t_q <= 1'b1;
            end else begin
              state_q <= S_RCHK;
            end
          end
        end
        S_DONE: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          zone_q     <= zone_index_i;
          v_q[0][0]  <= v0_x_i;
          v_q[0][1]  <= v0_y_i;
          v_q[0][2]  <= v0_z_i;
          v_q[1][0]  <= v1_x_i;
          v_q[1][1]  <= v1_y_i;
          v_q[1][2]  <= v1_z_i;
          v_q[2][0]  <= v2_x_i;
          v_q[2][1]  <= v2_y_i;
          v_q[2][2]  <= v2_z_i;
          nm_q[0]    <= sum_x[33] ? 34'(-sum_x) : 34'(sum_x);
          nm_q[1]    <= sum_y[33] ? 34'(-sum_y) : 34'(sum_y);
          nm_q[2]    <= sum_z[33] ? 34'(-sum_z) : 34'(sum_z);
          nneg_q     <= {sum_z[33], sum_y[33], sum_x[33]};
        end
      end
      S_ALIGN: begin
        if (all_zero) begin
          for (int i = 0; i < 3; i++) begin
            if (nsel_q) begin
              ax_q[i] <= '0;
            end else begin
              ctr_q[i] <= '0;
            end
          end
        end else if (any_hi) begin
          for (int i = 0; i < 3; i++) begin
            nm_q[i] <= nm_q[i] >> 1;
          end
        end else if (all_lo) begin
          for (int i = 0; i < 3; i++) begin
            nm_q[i] <= nm_q[i] << 1;
          end
        end else begin
          acc_q <= '0;
        end
      end
      S_SQ: begin
        if (ph_q) begin
          acc_q <= acc_q + prod_q;
          if (k_q == 2'd2) begin
            sx_q   <= 64'(acc_q + prod_q);
            sres_q <= '0;
            sbit_q <= SQRT_TOP;
          end
        end
      end
      S_SQRT: begin
        if (sbit_q != '0) begin
          if (sq_ge) begin
            sx_q   <= sx_q - sq_t;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      S_NDIV, S_HDIV: begin
        ovf_q <= 32'(div_num[63:33]) >= sres_q[31:0];
        rem_q <= 32'(div_num[63:33]);
        dq_q  <= div_num[32:0];
        den_q <= sres_q[31:0];
        quo_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_sub[31:0] : div_tr[31:0];
        quo_q <= {quo_q[31:0], div_ge};
        dq_q  <= dq_q << 1;
      end
      S_NST: begin
        if (nsel_q) begin
          ax_q[k_q] <= n_val;
        end else begin
          ctr_q[k_q] <= n_val;
        end
      end
      S_NFIN: begin
        if (!nsel_q) begin
          nm_q[0] <= ctr_q[1][31] ? 34'(-sx34(ctr_q[1])) : 34'(sx34(ctr_q[1]));
          nm_q[1] <= ctr_q[0][31] ? 34'(-sx34(ctr_q[0])) : 34'(sx34(ctr_q[0]));
          nm_q[2] <= '0;
          nneg_q  <= {1'b0, ctr_q[0][31], (ctr_q[1] > 0)};
        end
      end
      S_BX: begin
        if (ph_q) begin
          acc_q <= t_q ? acc_q - prod_q : prod_q;
        end
      end
      S_BXST: begin
        bx_q[k_q] <= sat_one(fx_round(acc_q));
      end
      S_PROJ: begin
        if (!ph_q && k_q == 2'd0 && !t_q) begin
          mu0_q <= '0;
          mu1_q <= '0;
        end else if (ph_q) begin
          if (t_q) begin
            mu1_q <= mu1_q + rnd[35:0];
          end else begin
            mu0_q <= mu0_q + rnd[35:0];
          end
        end
      end
      S_RAD: begin
        if (ph_q) begin
          acc_q <= t_q ? acc_q - prod_q : ONE_SQ - prod_q;
        end
      end
      S_RCHK: begin
        if (acc_q > 0) begin
          sx_q   <= 64'(acc_q);
          sres_q <= '0;
          sbit_q <= SQRT_TOP;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign zone_out_o  = zone_q;
  assign center_x_o  = ctr_q[0];
  assign center_y_o  = ctr_q[1];
  assign center_z_o  = ctr_q[2];
  assign axis_a_x_o  = ax_q[0];
  assign axis_a_y_o  = ax_q[1];
  assign axis_a_z_o  = ax_q[2];
  assign axis_b_x_o  = bx_q[0];
  assign axis_b_y_o  = bx_q[1];
  assign axis_b_z_o  = bx_q[2];
  assign scale_max_o = run_q;

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("A result is pending while the input side is open.");

  a_scale_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_max_o >= $past(scale_max_o))
    else $error("The running scale decreased.");

  a_center_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_x_o <= ONE_S32 && center_x_o >= -ONE_S32 &&
                     axis_b_z_o <= ONE_S32 && axis_b_z_o >= -ONE_S32))
    else $error("A normalized component lies outside the unit range.");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < 6'(DIV_STEPS))
    else $error("The divider ran past its step count.");

endmodule
